// File: hw/rtl/pbsc_pkg.sv
package pbsc_pkg;

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] HOLD_TICKS_RST = 16'd2000;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Mode codes as reported on the result channel
  localparam logic [2:0] MODE_FIRST   = 3'd0;
  localparam logic [2:0] MODE_IDLE    = 3'd1;
  localparam logic [2:0] MODE_START   = 3'd2;
  localparam logic [2:0] MODE_WAIT    = 3'd3;
  localparam logic [2:0] MODE_EXPIRED = 3'd4;
  localparam logic [2:0] MODE_SLEEP   = 3'd5;
  localparam logic [2:0] MODE_ASLEEP  = 3'd6;
  localparam logic [2:0] MODE_WAKE    = 3'd7;

  typedef enum logic [7:0] {
    ST_FIRST   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_START   = 8'b0000_0100,
    ST_WAIT    = 8'b0000_1000,
    ST_EXPIRED = 8'b0001_0000,
    ST_SLEEP   = 8'b0010_0000,
    ST_ASLEEP  = 8'b0100_0000,
    ST_WAKE    = 8'b1000_0000
  } state_t;

  // Result item, power_off in the lowest bit
  typedef struct packed {
    logic [2:0] mode_code;
    logic       sleep_off;
    logic       sleep_on;
    logic       power_off;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  function automatic logic [2:0] mode_code_of(input state_t st);
    logic [2:0] code;
    code = MODE_FIRST;
    case (st)
      ST_FIRST:   code = MODE_FIRST;
      ST_IDLE:    code = MODE_IDLE;
      ST_START:   code = MODE_START;
      ST_WAIT:    code = MODE_WAIT;
      ST_EXPIRED: code = MODE_EXPIRED;
      ST_SLEEP:   code = MODE_SLEEP;
      ST_ASLEEP:  code = MODE_ASLEEP;
      ST_WAKE:    code = MODE_WAKE;
      default:    code = MODE_FIRST;
    endcase
    return code;
  endfunction

endpackage

// File: hw/rtl/power_button_sleep_controller.sv
// Channel  Dir  Ports                              Contents
// in_      in   in_tvalid/in_tready/in_tdata[7:0]  one button sample per tick
// out_     out  out_tvalid/out_tready/out_tdata    pulses and mode per tick
// cfg_     in   cfg_wr_en/cfg_wr_data[15:0]        hold_ticks
//
// One request per clock while in_tready is high; results are registered.
// The state update is a single pass through the controller logic.
// A two-entry output buffer holds results under backpressure; in_tready
// drops only when both entries are full.
// rst_n is synchronous: state to first press, hold_ticks to 2000.
module power_button_sleep_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] button_down, [1] display_asleep
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] power_off, [1] sleep_on, [2] sleep_off,
                                  // [5:3] mode_code
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import pbsc_pkg::*;

  logic step;
  res_t res;
  res_t rd_data;

  assign step = in_tvalid && in_tready;

  pbsc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .step           (step),
    .button_down    (in_tdata[0]),
    .display_asleep (in_tdata[1]),
    .res            (res)
  );

  pbsc_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (res),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (rd_data)
  );

  assign out_tdata = {{(8 - RES_W){1'b0}}, rd_data};

endmodule

// File: hw/rtl/pbsc_core.sv
module pbsc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  step,
  input  logic                  button_down,
  input  logic                  display_asleep,
  output pbsc_pkg::res_t        res
);
  import pbsc_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] hold_ticks_r;
  logic [CNT_W-1:0] held_inc;

  assign held_inc = (held_r != CNT_MAX) ? held_r + 1'b1 : held_r;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    res.power_off = 1'b0;
    res.sleep_on  = 1'b0;
    res.sleep_off = 1'b0;
    case (state_r)
      ST_FIRST: begin
        if (!button_down) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (button_down) state_nxt = ST_START;
      end
      ST_START: begin
        if (button_down) begin
          held_nxt  = '0;
          state_nxt = ST_WAIT;
        end else begin
          state_nxt = ST_SLEEP;
        end
      end
      ST_WAIT: begin
        if (button_down) begin
          held_nxt = held_inc;
          // zero hold time expires like one
          if (held_inc >= hold_ticks_r) state_nxt = ST_EXPIRED;
        end else begin
          state_nxt = ST_SLEEP;
        end
      end
      ST_EXPIRED: begin
        res.power_off = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SLEEP: begin
        res.sleep_on = !display_asleep;
        state_nxt    = ST_ASLEEP;
      end
      ST_ASLEEP: begin
        if (button_down) begin
          res.sleep_off = 1'b1;
          state_nxt     = ST_WAKE;
        end
      end
      ST_WAKE: begin
        if (!button_down) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_FIRST;
      end
    endcase
    res.mode_code = mode_code_of(state_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FIRST;
      held_r       <= '0;
      hold_ticks_r <= HOLD_TICKS_RST;
    end else begin
      if (cfg_wr_en) hold_ticks_r <= cfg_wr_data;
      if (step) begin
        state_r <= state_nxt;
        held_r  <= held_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/pbsc_obuf.sv
module pbsc_obuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  pbsc_pkg::res_t        wr_data,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output pbsc_pkg::res_t        rd_data
);
  import pbsc_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_r;
  res_t skid_r;
  logic take;
  logic push;

  assign wr_ready = !skid_valid_r;
  assign push     = wr_valid && wr_ready;
  assign take     = out_valid_r && rd_ready;
  assign rd_valid = out_valid_r;
  assign rd_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload path, no reset
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) out_r <= skid_r;
    end else if (push) begin
      if (!out_valid_r || take) out_r <= wr_data;
      else                      skid_r <= wr_data;
    end
  end

endmodule

// File: test/tb_power_button_sleep_controller.sv
`timescale 1ns / 100ps

module tb_power_button_sleep_controller;
  import pbsc_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  power_button_sleep_controller uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predicted controller state and setting
  logic [2:0]       fsm_mode = MODE_FIRST;
  logic [CNT_W-1:0] hold_count = '0;
  logic [CNT_W-1:0] hold_limit = HOLD_TICKS_RST;

  logic [7:0] button_samples[$];
  res_t       tick_results[$];

  int err_count = 0;
  int result_idx = 0;
  int quiet_cycles = 0;

  // Sender burst shaping
  int burst_left = 1;
  int gap_left = 0;
  logic drv_next_valid;

  // Receiver stall shaping
  int stall_pct = 0;
  int stall_phase_cnt = 0;

  res_t pred_res;
  res_t got_res;
  res_t exp_res;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic button_fsm_tick(input logic down, input logic asleep_in, output res_t r);
    r = '0;
    case (fsm_mode)
      MODE_FIRST: begin
        if (!down) fsm_mode = MODE_IDLE;
      end
      MODE_IDLE: begin
        if (down) fsm_mode = MODE_START;
      end
      MODE_START: begin
        if (down) begin
          hold_count = '0;
          fsm_mode = MODE_WAIT;
        end else begin
          fsm_mode = MODE_SLEEP;
        end
      end
      MODE_WAIT: begin
        if (down) begin
          if (hold_count != CNT_MAX) hold_count = hold_count + 1'b1;
          if (hold_count >= hold_limit) fsm_mode = MODE_EXPIRED;
        end else begin
          fsm_mode = MODE_SLEEP;
        end
      end
      MODE_EXPIRED: begin
        r.power_off = 1'b1;
        fsm_mode = MODE_IDLE;
      end
      MODE_SLEEP: begin
        if (!asleep_in) r.sleep_on = 1'b1;
        fsm_mode = MODE_ASLEEP;
      end
      MODE_ASLEEP: begin
        if (down) begin
          r.sleep_off = 1'b1;
          fsm_mode = MODE_WAKE;
        end
      end
      default: begin
        if (!down) fsm_mode = MODE_IDLE;
      end
    endcase
    r.mode_code = fsm_mode;
  endtask

  task automatic report_mismatch(input string field, input int got_v, input int exp_v);
    $display("MISMATCH request %0d %s: got %0d expected %0d", result_idx, field, got_v, exp_v);
    err_count++;
  endtask

  task automatic push_sample(input logic down, input logic asleep_in);
    button_samples.push_back({6'd0, asleep_in, down});
  endtask

  // Level held for len ticks, display_asleep random per tick
  task automatic push_level(input logic down, input int len);
    for (int i = 0; i < len; i++) push_sample(down, 1'($urandom_range(0, 1)));
  endtask

  // Mostly press/release sequences, some raw noise
  task automatic push_random_phase(input int n_items);
    int cnt;
    int len;
    int kind;
    cnt = 0;
    while (cnt < n_items) begin
      kind = int'($urandom_range(0, 9));
      if (kind == 0) begin
        len = int'($urandom_range(1, 4));
        for (int i = 0; i < len; i++)
          push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        cnt += len;
      end else begin
        if (kind < 6) len = int'($urandom_range(1, 3));
        else len = int'(hold_limit) + int'($urandom_range(0, 4));
        if (len < 1) len = 1;
        push_level(1'b1, len);
        cnt += len;
        len = int'($urandom_range(1, 4));
        push_level(1'b0, len);
        cnt += len;
      end
    end
  endtask

  task automatic wait_idle();
    while (button_samples.size() != 0 || in_tvalid || tick_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_hold(input logic [15:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hold_limit = v;
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        button_fsm_tick(in_tdata[0], in_tdata[1], pred_res);
        tick_results.push_back(pred_res);
      end
      if (!in_tvalid || in_tready) begin
        drv_next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (button_samples.size() != 0) begin
          drv_next_valid = 1'b1;
          in_tdata <= button_samples.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = int'($urandom_range(1, 40));
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
          end
        end
        in_tvalid <= drv_next_valid;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res = res_t'(out_tdata[RES_W-1:0]);
        if (tick_results.size() == 0) begin
          report_mismatch("unexpected request", out_tdata, 0);
        end else begin
          exp_res = tick_results.pop_front();
          if (got_res.power_off != exp_res.power_off)
            report_mismatch("power_off", got_res.power_off, exp_res.power_off);
          if (got_res.sleep_on != exp_res.sleep_on)
            report_mismatch("sleep_on", got_res.sleep_on, exp_res.sleep_on);
          if (got_res.sleep_off != exp_res.sleep_off)
            report_mismatch("sleep_off", got_res.sleep_off, exp_res.sleep_off);
          if (got_res.mode_code != exp_res.mode_code)
            report_mismatch("mode_code", got_res.mode_code, exp_res.mode_code);
        end
        result_idx++;
      end
      stall_phase_cnt++;
      if (stall_phase_cnt >= 200) begin
        stall_phase_cnt = 0;
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    // Power-on press is ignored until first release
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b0);
    push_sample(1'b0, 1'b1);
    // Short press, sleep requested, wake on next press
    push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b0);
    // Release from wait, display already asleep: no sleep_on
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b1);
    push_sample(1'b1, 1'b1);
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b1);
    // Hold at default setting until it expires
    push_level(1'b1, int'(HOLD_TICKS_RST) + 3);
    push_level(1'b0, 2);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_hold(16'd1);
    push_random_phase(60);
    // Zero hold time behaves as one
    write_hold(16'd0);
    push_random_phase(50);
    // Longest hold: short presses never expire
    write_hold(16'hFFFF);
    push_level(1'b0, 2);
    push_level(1'b1, 10);
    push_level(1'b0, 3);
    write_hold(16'd5);
    push_random_phase(60);
    write_hold(16'($urandom_range(2, 12)));
    push_random_phase(60);
    write_hold(16'd1);
    push_random_phase(50);

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pbsc_pkg.sv
hw/rtl/pbsc_core.sv
hw/rtl/pbsc_obuf.sv
hw/rtl/power_button_sleep_controller.sv
test/tb_power_button_sleep_controller.sv
